@@ rtl/kmsd_pkg.sv @@
// Package for the key and mouse sequence decoder: payload types, codes and character constants.
package kmsd_pkg;

    localparam int OUT_NUM_W = 16;

    localparam logic [2:0] EV_CHAR  = 3'd0;
    localparam logic [2:0] EV_FKEY  = 3'd1;
    localparam logic [2:0] EV_CLICK = 3'd2;
    localparam logic [2:0] EV_DRAG  = 3'd3;
    localparam logic [2:0] EV_ALERT = 3'd4;

    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_M      = 8'h6D;
    localparam logic [7:0] CH_P      = 8'h70;
    localparam logic [7:0] CH_UP_H   = 8'h48;
    localparam logic [7:0] CH_UP_L   = 8'h4C;
    localparam logic [7:0] CH_J      = 8'h6A;
    localparam logic [7:0] CH_K      = 8'h6B;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_CTRL_Z = 8'h1A;
    localparam logic [7:0] CH_CTRL_B = 8'h02;
    localparam logic [7:0] CH_CTRL_F = 8'h06;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;

    localparam logic [7:0] PREFIX_RESET = 8'h12;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       normal_mode;
    } t_in_item;

    typedef struct packed {
        logic [2:0]           event_kind;
        logic [7:0]           key_code;
        logic [OUT_NUM_W-1:0] first_num;
        logic [OUT_NUM_W-1:0] second_num;
        logic [OUT_NUM_W-1:0] third_num;
        logic [OUT_NUM_W-1:0] fourth_num;
    } t_out_item;

    // Classified byte passed from the front to the back.
    typedef struct packed {
        logic [7:0] code;
        logic       normal;
        logic       is_prefix;
        logic       is_fkey;
        logic       is_drag_start;
        logic       is_click_start;
        logic       is_semi;
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_ctrl_z;
    } t_token;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

@@ rtl/key_mouse_sequence_decoder_core.sv @@
// Top level of the key and mouse control-sequence decoder.
//
//  channel   direction  handshake               payload
//  input     in         i_valid / o_stall       i_data (t_in_item)
//  result    out        o_valid / i_stall       o_data (t_out_item)
//  config    in         i_cfg_valid/o_cfg_ready i_cfg_data (prefix byte)
//
// One byte per cycle sustained while the token queue is not full; each byte is first
// written into a queue entry, then the parser updates the result register from it.
// The parser handles one queued token per cycle while the result register is free; the queue decouples input stalls.
// Reset is synchronous; prefix returns to control-R, parser to idle, queue empty.
// o_stall rises only when the token queue is full.
module key_mouse_sequence_decoder_core
    import kmsd_pkg::*;
#(
    parameter int NUM_WIDTH   = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_in_item   i_data,
    output logic       o_valid,
    input  logic       i_stall,
    output t_out_item  o_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    t_token    token_in;
    t_token    token_out;
    t_q_status q_status;
    logic      push;
    logic      pop;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = q_status.full;
    assign push        = i_valid && !q_status.full;

    kmsd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_data),
        .o_token     (token_in)
    );

    kmsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (token_in),
        .i_pop    (pop),
        .o_data   (token_out),
        .o_status (q_status)
    );

    kmsd_back #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_token    (token_out),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data)
    );

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

    a_plain_no_nums: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.event_kind == EV_CHAR || o_data.event_kind == EV_FKEY ||
                    o_data.event_kind == EV_ALERT)
        |-> o_data.first_num == '0 && o_data.second_num == '0 &&
            o_data.third_num == '0 && o_data.fourth_num == '0)
        else $error("numbers set on key result");

    a_mouse_no_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.event_kind == EV_CLICK || o_data.event_kind == EV_ALERT)
        |-> o_data.key_code == '0 && o_data.third_num == '0)
        else $error("stray fields on click or alert");

    a_full_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.full && !pop |=> q_status.full)
        else $error("queue lost an entry");

endmodule

@@ rtl/kmsd_front.sv @@
// Front end: prefix register and byte classification.
module kmsd_front
    import kmsd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_valid,
    input  logic [7:0] i_cfg_data,
    input  t_in_item i_item,
    output t_token   o_token
);

    logic [7:0] r_prefix;
    logic [7:0] c;
    logic       dec_digit;
    logic       lo_hex;
    logic       up_hex;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix <= PREFIX_RESET;
        end else if (i_cfg_valid) begin
            r_prefix <= i_cfg_data;
        end
    end

    assign c         = i_item.in_byte;
    assign dec_digit = (c >= CH_0) && (c <= CH_9);
    assign lo_hex    = (c >= CH_LO_A) && (c <= CH_LO_F);
    assign up_hex    = (c >= CH_UP_A) && (c <= CH_UP_F);

    always_comb begin
        o_token.code           = c;
        o_token.normal         = i_item.normal_mode;
        o_token.is_prefix      = (c == r_prefix);
        o_token.is_fkey        = (c == CH_CTRL_B) || (c == CH_CTRL_F) || (c == CH_UP_H) ||
                                 (c == CH_UP_L) || (c == CH_BS) || (c == CH_SPACE) ||
                                 (c == CH_J) || (c == CH_K);
        o_token.is_drag_start  = (c == CH_M);
        o_token.is_click_start = (c == CH_P);
        o_token.is_semi        = (c == CH_SEMI);
        o_token.is_hex         = dec_digit || lo_hex || up_hex;
        o_token.hex_val        = dec_digit ? c[3:0] : (c[3:0] + 4'd9);
        o_token.is_ctrl_z      = (c == CH_CTRL_Z);
    end

endmodule

@@ rtl/kmsd_queue.sv @@
// Small token queue between the front and the back.
module kmsd_queue
    import kmsd_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_token    i_data,
    input  logic      i_pop,
    output t_token    o_data,
    output t_q_status o_status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    t_token             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    assign o_data         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

@@ rtl/kmsd_back.sv @@
// Back end: sequence parser and registered result stage.
module kmsd_back
    import kmsd_pkg::*;
#(
    parameter int NUM_WIDTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_token    i_token,
    input  t_q_status i_q_status,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PREFIX,
        PH_NUMS
    } t_phase;

    typedef logic [NUM_WIDTH-1:0] t_num;

    t_phase    r_phase, n_phase;
    logic      r_drag, n_drag;
    logic [1:0] r_idx, n_idx;
    t_num      r_acc, n_acc;
    t_num      r_saved [3];
    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;
    logic      out_free;
    logic      save_en;
    t_out_item blank;

    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = !i_q_status.empty && out_free;

    always_comb begin
        blank = '0;
        n_phase     = r_phase;
        n_drag      = r_drag;
        n_idx       = r_idx;
        n_acc       = r_acc;
        n_out       = r_out;
        n_out_valid = r_out_valid && !out_free;
        save_en     = 1'b0;
        if (o_pop) begin
            case (r_phase)
                PH_PREFIX: begin
                    n_phase = PH_IDLE;
                    if (i_token.is_prefix) begin
                        n_out_valid    = 1'b1;
                        n_out          = blank;
                        n_out.key_code = i_token.code;
                    end else if (i_token.is_fkey) begin
                        n_out_valid = 1'b1;
                        n_out       = blank;
                        if (i_token.normal) begin
                            n_out.event_kind = EV_FKEY;
                            n_out.key_code   = i_token.code;
                        end else begin
                            n_out.event_kind = EV_ALERT;
                        end
                    end else if (i_token.is_drag_start || i_token.is_click_start) begin
                        n_phase = PH_NUMS;
                        n_drag  = i_token.is_drag_start;
                        n_idx   = 2'd0;
                        n_acc   = '0;
                    end
                end
                PH_NUMS: begin
                    if (i_token.is_semi) begin
                        if (r_idx >= (r_drag ? 2'd3 : 2'd1)) begin
                            n_phase = PH_IDLE;
                            n_idx   = 2'd0;
                            n_acc   = '0;
                            if (i_token.normal) begin
                                n_out_valid      = 1'b1;
                                n_out            = blank;
                                n_out.first_num  = OUT_NUM_W'(r_saved[0]);
                                if (r_drag) begin
                                    n_out.event_kind = EV_DRAG;
                                    n_out.second_num = OUT_NUM_W'(r_saved[1]);
                                    n_out.third_num  = OUT_NUM_W'(r_saved[2]);
                                    n_out.fourth_num = OUT_NUM_W'(r_acc);
                                end else begin
                                    n_out.event_kind = EV_CLICK;
                                    n_out.second_num = OUT_NUM_W'(r_acc);
                                end
                            end
                        end else begin
                            save_en = 1'b1;
                            n_idx   = r_idx + 2'd1;
                            n_acc   = '0;
                        end
                    end else if (i_token.is_hex) begin
                        n_acc = {r_acc[NUM_WIDTH-5:0], i_token.hex_val};
                    end else begin
                        n_phase = PH_IDLE;
                        n_idx   = 2'd0;
                        n_acc   = '0;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    if (i_token.is_prefix) begin
                        n_phase = PH_PREFIX;
                    end else begin
                        n_out_valid = 1'b1;
                        n_out       = blank;
                        if (i_token.is_ctrl_z && i_token.normal) begin
                            n_out.event_kind = EV_ALERT;
                        end else begin
                            n_out.key_code = i_token.code;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_drag      <= 1'b0;
            r_idx       <= 2'd0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_drag      <= n_drag;
            r_idx       <= n_idx;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
            r_out       <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (save_en && (r_idx != 2'd3)) begin
            r_saved[r_idx] <= r_acc;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
